// ===== hdl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared widths, codes and defaults of the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 128;

  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int CELL_ROW_W = 6;
  localparam int CELL_COL_W = 7;
  localparam int CELL_W     = 16;
  localparam int CUR_ROW_W  = 6;
  localparam int CUR_COL_W  = 8;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int ROWS_REG_W = 7;
  localparam int COLS_REG_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS = 1'b1;

  localparam logic [ROWS_REG_W-1:0] ROWS_RST = 7'd25;
  localparam logic [COLS_REG_W-1:0] COLS_RST = 8'd80;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_TAB        = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF         = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR         = 8'h0D;
  localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'h20;
  localparam logic [CHAR_W-1:0] TEXT_ATTR       = 8'h07;
  localparam int                TAB_STOP        = 8;

endpackage

// ===== hdl/tccw_ram.sv =====
// ----------------------------------------------------------------------------
// tccw_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tccw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tccw_addr_unit.sv =====
// ----------------------------------------------------------------------------
// tccw_addr_unit
// Shared registered multiply-add: linear cell addresses and screen size.
// ----------------------------------------------------------------------------
module tccw_addr_unit #(
  parameter int A_W   = 7,
  parameter int B_W   = 8,
  parameter int OUT_W = 14
) (
  input  logic             clk,
  input  logic [A_W-1:0]   a,
  input  logic [B_W-1:0]   b,
  input  logic [B_W-1:0]   addend,
  output logic [OUT_W-1:0] sum
);

  localparam int PW = A_W + B_W + 1;

  logic [PW-1:0]    full;
  logic [OUT_W-1:0] sum_r;

  assign full = PW'(a) * PW'(b) + PW'(addend);

  always_ff @(posedge clk) begin
    sum_r <= full[OUT_W-1:0];
  end

  assign sum = sum_r;

endmodule

// ===== hdl/text_console_cell_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer_unit
// Text console engine: cell store, cursor, scroll and clear sequencer.
// ----------------------------------------------------------------------------
// A printable byte and a read go through the registered multiply-add for the cell
// address; a scroll copies one cell a cycle through the store's single write port,
// then blanks the last row, and a clear sweeps the whole store. One item at a time.
// Reset: synchronous; the store is then swept to zero with in_stall high.
// Configuration writes are taken at any time.
module text_console_cell_writer_unit #(
  parameter int MAX_ROWS = tccw_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tccw_pkg::MAX_COLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tccw_pkg::MODE_W-1:0]      in_mode,
  input  logic [tccw_pkg::CHAR_W-1:0]      in_char_code,
  input  logic [tccw_pkg::CELL_ROW_W-1:0]  in_cell_row,
  input  logic [tccw_pkg::CELL_COL_W-1:0]  in_cell_col,
  input  logic                             in_end_of_string,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [tccw_pkg::CELL_W-1:0]      out_cell_data,
  output logic [tccw_pkg::CUR_ROW_W-1:0]   out_cursor_row,
  output logic [tccw_pkg::CUR_COL_W-1:0]   out_cursor_col,
  output logic                             out_scrolled,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tccw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tccw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import tccw_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_CLR  = 4'd2;
  localparam logic [3:0] ST_SLIM = 4'd3;
  localparam logic [3:0] ST_SCR  = 4'd4;
  localparam logic [3:0] ST_MUL  = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_RDD  = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  localparam logic [CNT_W-1:0] LAST_ADDR = CNT_W'(DEPTH - 1);

  logic [3:0]            state_r, state_nxt;
  logic [ROWS_REG_W-1:0] rows_r;
  logic [COLS_REG_W-1:0] cols_r;
  logic [RW-1:0]         row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [CNT_W-1:0]      src_r, src_nxt;
  logic [CNT_W-1:0]      dst_r, dst_nxt;
  logic                  pend_r, pend_nxt;
  logic                  scr_r, scr_nxt;
  logic                  wr_cell_r, wr_cell_nxt;
  logic                  rd_op_r, rd_op_nxt;
  logic [CHAR_W-1:0]     char_r, char_nxt;
  logic [CELL_W-1:0]     data_r, data_nxt;
  logic [RCW-1:0]        mul_a_r, mul_a_nxt;
  logic [CW-1:0]         mul_b_r, mul_b_nxt;
  logic [CW-1:0]         mul_add_r, mul_add_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]     out_data_r, out_data_nxt;
  logic [CUR_ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [CUR_COL_W-1:0]  out_col_r, out_col_nxt;
  logic                  out_scr_r, out_scr_nxt;

  logic [RCW-1:0]        r_eff;
  logic [CW-1:0]         c_eff;
  logic [RW-1:0]         r_m1;
  logic [RW-1:0]         row_cl;
  logic [RW-1:0]         row_inc;
  logic [CW-1:0]         col_cl;
  logic                  at_bottom;
  logic [CW:0]           tab_sum;
  logic [CW:0]           tab_al;
  logic [CW-1:0]         tab_col;
  logic                  rd_go;

  logic [CNT_W-1:0]      au_sum;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [CELL_W-1:0]     ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [CELL_W-1:0]     ram_rdata;

  tccw_addr_unit #(
    .A_W   (RCW),
    .B_W   (CW),
    .OUT_W (CNT_W)
  ) u_addr (
    .clk    (clk),
    .a      (mul_a_r),
    .b      (mul_b_r),
    .addend (mul_add_r),
    .sum    (au_sum)
  );

  tccw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective geometry and clamped cursor
  always_comb begin
    if (rows_r == '0) begin
      r_eff = RCW'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      r_eff = RCW'(MAX_ROWS);
    end else begin
      r_eff = RCW'(rows_r);
    end
    if (cols_r == '0) begin
      c_eff = CW'(1);
    end else if (32'(cols_r) > MAX_COLS) begin
      c_eff = CW'(MAX_COLS);
    end else begin
      c_eff = CW'(cols_r);
    end
    r_m1      = RW'(r_eff - RCW'(1));
    row_cl    = (row_r > r_m1) ? r_m1 : row_r;
    col_cl    = (col_r > c_eff) ? c_eff : col_r;
    at_bottom = (row_cl >= r_m1);
    row_inc   = row_cl + RW'(1);
    tab_sum   = (CW+1)'(col_cl) + (CW+1)'(TAB_STOP);
    tab_al    = tab_sum & ~((CW+1)'(TAB_STOP - 1));
    tab_col   = (tab_al > (CW+1)'(c_eff)) ? c_eff : CW'(tab_al);
  end

  assign rd_go     = (src_r < au_sum);
  assign ram_raddr = (state_r == ST_SCR) ? src_r[AW-1:0] : au_sum[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    pend_nxt      = pend_r;
    scr_nxt       = scr_r;
    wr_cell_nxt   = wr_cell_r;
    rd_op_nxt     = rd_op_r;
    char_nxt      = char_r;
    data_nxt      = data_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_add_nxt   = mul_add_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_scr_nxt   = out_scr_r;
    ram_we        = 1'b0;
    ram_waddr     = dst_r[AW-1:0];
    ram_wdata     = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_INIT: begin
        ram_we  = 1'b1;
        dst_nxt = dst_r + CNT_W'(1);
        if (dst_r == LAST_ADDR) begin
          dst_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          row_nxt     = row_cl;
          col_nxt     = col_cl;
          data_nxt    = '0;
          scr_nxt     = 1'b0;
          wr_cell_nxt = 1'b0;
          rd_op_nxt   = 1'b0;
          char_nxt    = in_char_code;
          src_nxt     = CNT_W'(c_eff);
          dst_nxt     = '0;
          pend_nxt    = 1'b0;
          mul_a_nxt   = r_eff;
          mul_b_nxt   = c_eff;
          mul_add_nxt = '0;
          state_nxt   = ST_DONE;
          case (in_mode)
            MODE_WRITE: begin
              if (in_char_code == CHAR_LF) begin
                col_nxt = '0;
                if (at_bottom) begin
                  scr_nxt   = 1'b1;
                  row_nxt   = r_m1;
                  state_nxt = ST_SLIM;
                end else begin
                  row_nxt = row_inc;
                end
              end else if (in_char_code == CHAR_CR) begin
                col_nxt = '0;
              end else if (in_char_code == CHAR_TAB) begin
                col_nxt = tab_col;
              end else if (in_char_code >= FIRST_PRINTABLE) begin
                wr_cell_nxt = 1'b1;
                if (col_cl >= c_eff) begin
                  col_nxt = '0;
                  if (at_bottom) begin
                    scr_nxt   = 1'b1;
                    row_nxt   = r_m1;
                    state_nxt = ST_SLIM;
                  end else begin
                    row_nxt   = row_inc;
                    mul_a_nxt = RCW'(row_inc);
                    state_nxt = ST_MUL;
                  end
                end else begin
                  mul_a_nxt   = RCW'(row_cl);
                  mul_add_nxt = col_cl;
                  state_nxt   = ST_MUL;
                end
              end
            end
            MODE_READ: begin
              if ((RCW'(in_cell_row) < r_eff) && (CW'(in_cell_col) < c_eff)) begin
                rd_op_nxt   = 1'b1;
                mul_a_nxt   = RCW'(in_cell_row);
                mul_add_nxt = CW'(in_cell_col);
                state_nxt   = ST_MUL;
              end
            end
            MODE_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              state_nxt = ST_CLR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CLR: begin
        ram_we  = 1'b1;
        dst_nxt = dst_r + CNT_W'(1);
        if (dst_r == LAST_ADDR) begin
          dst_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_SLIM: begin
        state_nxt = ST_SCR;
      end
      ST_SCR: begin
        // read row below, write it one row up; then blank the last row
        pend_nxt = rd_go;
        if (rd_go) begin
          src_nxt = src_r + CNT_W'(1);
        end
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          dst_nxt   = dst_r + CNT_W'(1);
        end else if (!rd_go && (dst_r < au_sum)) begin
          ram_we  = 1'b1;
          dst_nxt = dst_r + CNT_W'(1);
        end else if (!rd_go) begin
          if (wr_cell_r) begin
            mul_a_nxt   = RCW'(row_r);
            mul_b_nxt   = c_eff;
            mul_add_nxt = col_r;
            state_nxt   = ST_MUL;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (rd_op_r) begin
          state_nxt = ST_RDD;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = au_sum[AW-1:0];
          ram_wdata = {TEXT_ATTR, char_r};
          col_nxt   = col_r + CW'(1);
          state_nxt = ST_DONE;
        end
      end
      ST_RDD: begin
        data_nxt  = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = data_r;
          out_row_nxt   = CUR_ROW_W'(row_r);
          out_col_nxt   = CUR_COL_W'(col_r);
          out_scr_nxt   = scr_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      rows_r      <= ROWS_RST;
      cols_r      <= COLS_RST;
      row_r       <= '0;
      col_r       <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      pend_r      <= 1'b0;
      scr_r       <= 1'b0;
      wr_cell_r   <= 1'b0;
      rd_op_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      src_r       <= src_nxt;
      dst_r       <= dst_nxt;
      pend_r      <= pend_nxt;
      scr_r       <= scr_nxt;
      wr_cell_r   <= wr_cell_nxt;
      rd_op_r     <= rd_op_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SCREEN_ROWS: rows_r <= cfg_data[ROWS_REG_W-1:0];
          CFG_SCREEN_COLS: cols_r <= cfg_data[COLS_REG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    data_r     <= data_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    mul_add_r  <= mul_add_nxt;
    out_data_r <= out_data_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_cell_data  = out_data_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_scrolled   = out_scr_r;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_console_cell_writer_unit. Drives write, read,
// clear and no-op items through the stall handshake and predicts every
// result from its own copy of the screen store, cursor and geometry. Covers
// tab and wrap at the edge, scrolls on the last row, a geometry shrunk under
// the cursor and clamped registers. It then runs long random text traffic
// under changing geometry and idling on both sides, and includes a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
  localparam int STORE_DEPTH    = MAX_ROWS_DEF * MAX_COLS_DEF;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int TIMEOUT_NS     = 40_000_000;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [CHAR_W-1:0]     char_code;
    logic [CELL_ROW_W-1:0] cell_row;
    logic [CELL_COL_W-1:0] cell_col;
    logic                  end_of_string;
  } console_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_data;
    logic [CUR_ROW_W-1:0] cursor_row;
    logic [CUR_COL_W-1:0] cursor_col;
    logic                 scrolled;
  } console_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode;
  logic [CHAR_W-1:0]     in_char_code;
  logic [CELL_ROW_W-1:0] in_cell_row;
  logic [CELL_COL_W-1:0] in_cell_col;
  logic                  in_end_of_string;
  logic                  out_valid;
  logic                  out_stall;
  logic [CELL_W-1:0]     out_cell_data;
  logic [CUR_ROW_W-1:0]  out_cursor_row;
  logic [CUR_COL_W-1:0]  out_cursor_col;
  logic                  out_scrolled;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predicted console state
  logic [CELL_W-1:0]     screen_image [0:STORE_DEPTH-1];
  int unsigned           model_row;
  int unsigned           model_col;
  logic [ROWS_REG_W-1:0] rows_reg;
  logic [COLS_REG_W-1:0] cols_reg;

  console_result_t pending_results [$];
  int unsigned     mismatch_count;
  int unsigned     useful_items;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  bit              hold_off_req;

  text_console_cell_writer_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_char_code     (in_char_code),
    .in_cell_row      (in_cell_row),
    .in_cell_col      (in_cell_col),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cell_data    (out_cell_data),
    .out_cursor_row   (out_cursor_row),
    .out_cursor_col   (out_cursor_col),
    .out_scrolled     (out_scrolled),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned eff_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > MAX_ROWS_DEF) return MAX_ROWS_DEF;
    return rows_reg;
  endfunction

  function automatic int unsigned eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > MAX_COLS_DEF) return MAX_COLS_DEF;
    return cols_reg;
  endfunction

  function automatic void scroll_image(input int unsigned r, input int unsigned c);
    int unsigned keep;
    keep = (r - 1) * c;
    for (int unsigned i = 0; i < keep; i++) screen_image[i] = screen_image[i + c];
    for (int unsigned i = keep; i < keep + c; i++) screen_image[i] = '0;
  endfunction

  function automatic console_result_t advance_console(input console_item_t it);
    int unsigned     r;
    int unsigned     c;
    int unsigned     nc;
    console_result_t res;
    r   = eff_rows();
    c   = eff_cols();
    res = '0;
    if (model_row > r - 1) model_row = r - 1;
    if (model_col > c) model_col = c;
    case (it.mode)
      MODE_WRITE: begin
        if (it.char_code == CHAR_LF) begin
          if (model_row >= r - 1) begin
            scroll_image(r, c);
            res.scrolled = 1'b1;
            model_row    = r - 1;
          end else begin
            model_row++;
          end
          model_col = 0;
        end else if (it.char_code == CHAR_CR) begin
          model_col = 0;
        end else if (it.char_code == CHAR_TAB) begin
          nc        = (model_col + TAB_STOP) & ~(TAB_STOP - 1);
          model_col = (nc > c) ? c : nc;
        end else if (it.char_code >= FIRST_PRINTABLE) begin
          if (model_col >= c) begin
            if (model_row + 1 > r - 1) begin
              scroll_image(r, c);
              res.scrolled = 1'b1;
              model_row    = r - 1;
            end else begin
              model_row++;
            end
            model_col = 0;
          end
          screen_image[model_row * c + model_col] = {TEXT_ATTR, it.char_code};
          model_col++;
        end
      end
      MODE_READ: begin
        if (it.cell_row < r && it.cell_col < c)
          res.cell_data = screen_image[it.cell_row * c + it.cell_col];
      end
      MODE_CLEAR: begin
        foreach (screen_image[i]) screen_image[i] = '0;
        model_row = 0;
        model_col = 0;
      end
      default: ;
    endcase
    res.cursor_row = CUR_ROW_W'(model_row);
    res.cursor_col = CUR_COL_W'(model_col);
    return res;
  endfunction

  function automatic console_item_t console_cmd(input logic [MODE_W-1:0] mode,
                                                input logic [CHAR_W-1:0] ch,
                                                input logic [CELL_ROW_W-1:0] row,
                                                input logic [CELL_COL_W-1:0] col,
                                                input logic eos);
    console_item_t it;
    it.mode          = mode;
    it.char_code     = ch;
    it.cell_row      = row;
    it.cell_col      = col;
    it.end_of_string = eos;
    return it;
  endfunction

  function automatic console_item_t random_item();
    console_item_t it;
    it.mode          = MODE_WRITE;
    it.char_code     = CHAR_W'($urandom_range(255));
    it.cell_row      = CELL_ROW_W'($urandom_range(63));
    it.cell_col      = CELL_COL_W'($urandom_range(127));
    it.end_of_string = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned expv,
                               input int unsigned actv);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected 0x%0h, got 0x%0h", what, expv, actv);
  endtask

  // one item per call; valid is left high so back-to-back transfers need no gap
  task automatic send_item(input console_item_t it);
    bit no_effect;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= it.mode;
    in_char_code     <= it.char_code;
    in_cell_row      <= it.cell_row;
    in_cell_col      <= it.cell_col;
    in_end_of_string <= it.end_of_string;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(advance_console(it));
    no_effect = (it.mode == MODE_NONE) ||
                (it.mode == MODE_WRITE && it.char_code < FIRST_PRINTABLE &&
                 it.char_code != CHAR_LF && it.char_code != CHAR_CR &&
                 it.char_code != CHAR_TAB);
    if (!no_effect) useful_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_SCREEN_ROWS) rows_reg = val[ROWS_REG_W-1:0];
    else cols_reg = val;
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] rows_v,
                              input logic [CFG_DATA_W-1:0] cols_v);
    drain();
    write_reg(CFG_SCREEN_ROWS, rows_v);
    write_reg(CFG_SCREEN_COLS, cols_v);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_LEN - 1) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    console_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_mismatch("transfer with nothing pending", 0, out_cell_data);
      end else begin
        want = pending_results.pop_front();
        if (out_cell_data !== want.cell_data)
          note_mismatch("cell_data", want.cell_data, out_cell_data);
        if (out_cursor_row !== want.cursor_row)
          note_mismatch("cursor_row", want.cursor_row, out_cursor_row);
        if (out_cursor_col !== want.cursor_col)
          note_mismatch("cursor_col", want.cursor_col, out_cursor_col);
        if (out_scrolled !== want.scrolled)
          note_mismatch("scrolled", want.scrolled, out_scrolled);
      end
    end
  end

  task automatic test_default_geometry();
    send_item(console_cmd(MODE_WRITE, 8'h41, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, 8'hFF, 6'h3F, 7'h7F, 1'b1));
    send_item(console_cmd(MODE_WRITE, FIRST_PRINTABLE, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, 8'h7F, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, 8'h00, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, 8'h1F, 6'd0, 7'd0, 1'b1));
    send_item(console_cmd(MODE_WRITE, CHAR_CR, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_READ, 8'h00, 6'd0, 7'd1, 1'b0));
    send_item(console_cmd(MODE_READ, 8'hFF, 6'h3F, 7'h7F, 1'b1));
    send_item(console_cmd(MODE_NONE, 8'h41, 6'd0, 7'd0, 1'b0));
    drain();
  endtask

  // tab saturation, wrap into the last row, wrap and newline on the last row
  task automatic test_tab_and_wrap();
    set_geometry(8'd2, 8'd10);
    send_item(console_cmd(MODE_WRITE, CHAR_TAB, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, 8'h78, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, CHAR_TAB, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, 8'h79, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, CHAR_TAB, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, CHAR_TAB, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, 8'h7A, 6'd0, 7'd0, 1'b1));
    send_item(console_cmd(MODE_WRITE, CHAR_LF, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_READ, 8'h00, 6'd0, 7'd0, 1'b0));
    drain();
  endtask

  // cursor clamped by a shrink to 1x1, then registers past their maximum
  task automatic test_shrink_and_clamp();
    send_item(console_cmd(MODE_WRITE, CHAR_TAB, 6'd0, 7'd0, 1'b0));
    set_geometry(8'h80, 8'h00);
    send_item(console_cmd(MODE_WRITE, CHAR_CR, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, 8'h71, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_WRITE, 8'h72, 6'd0, 7'd0, 1'b1));
    send_item(console_cmd(MODE_READ, 8'h00, 6'd0, 7'd0, 1'b0));
    set_geometry(8'hFF, 8'hFF);
    send_item(console_cmd(MODE_READ, 8'h00, 6'h3F, 7'h7F, 1'b0));
    send_item(console_cmd(MODE_WRITE, CHAR_LF, 6'd0, 7'd0, 1'b0));
    drain();
  endtask

  task automatic test_clear();
    send_item(console_cmd(MODE_CLEAR, 8'h00, 6'd0, 7'd0, 1'b0));
    send_item(console_cmd(MODE_READ, 8'h00, 6'd0, 7'd0, 1'b0));
    drain();
  endtask

  task automatic test_input_backpressure();
    console_item_t it;
    set_geometry(8'd4, 8'd8);
    send_idle_pct = 0;
    hold_off_req  = 1'b1;
    repeat (12) begin
      it = random_item();
      if ($urandom_range(4) == 0) it.char_code = CHAR_LF;
      else it.char_code = CHAR_W'($urandom_range(255, FIRST_PRINTABLE));
      send_item(it);
    end
    drain();
  endtask

  task automatic test_random_traffic();
    console_item_t         it;
    int unsigned           target;
    int unsigned           kind;
    int unsigned           len;
    int unsigned           sel;
    logic [CFG_DATA_W-1:0] rows_v;
    logic [CFG_DATA_W-1:0] cols_v;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 60;
        end
        1: begin
          send_idle_pct = 60;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        // mostly small screens so scrolls stay cheap
        sel    = $urandom_range(9);
        rows_v = {1'($urandom_range(1)), 7'($urandom_range(6, 1))};
        if (sel == 0) rows_v[6:0] = '0;
        else if (sel == 1) rows_v[6:0] = 7'($urandom_range(127, 64));
        sel    = $urandom_range(9);
        cols_v = 8'($urandom_range(24, 1));
        if (sel == 0) cols_v = '0;
        else if (sel == 1) cols_v = 8'($urandom_range(255, 129));
        set_geometry(rows_v, cols_v);
        target = useful_items + 40;
        while (useful_items < target) begin
          kind = $urandom_range(99);
          if (kind < 55) begin
            len = $urandom_range(16, 1);
            for (int unsigned k = 0; k < len; k++) begin
              it = random_item();
              if ($urandom_range(99) < 8) it.char_code = CHAR_TAB;
              else it.char_code = CHAR_W'($urandom_range(255, FIRST_PRINTABLE));
              it.end_of_string = (k == len - 1);
              send_item(it);
            end
            sel = $urandom_range(99);
            it  = random_item();
            if (sel < 55) begin
              it.char_code = CHAR_LF;
              send_item(it);
            end else if (sel < 70) begin
              it.char_code = CHAR_CR;
              send_item(it);
            end
          end else if (kind < 85) begin
            repeat ($urandom_range(3, 1)) begin
              it      = random_item();
              it.mode = MODE_READ;
              if ($urandom_range(99) < 85) begin
                it.cell_row = CELL_ROW_W'($urandom_range(eff_rows() - 1));
                it.cell_col = CELL_COL_W'($urandom_range(eff_cols() - 1));
              end
              send_item(it);
            end
          end else if (kind < 97) begin
            it = random_item();
            case ($urandom_range(2))
              0:       it.mode = MODE_WRITE;
              1:       it.mode = MODE_READ;
              default: it.mode = MODE_NONE;
            endcase
            send_item(it);
          end else begin
            it      = random_item();
            it.mode = MODE_CLEAR;
            send_item(it);
          end
        end
      end
    end
    drain();
  endtask

  initial begin
    in_valid         <= 1'b0;
    in_mode          <= MODE_WRITE;
    in_char_code     <= '0;
    in_cell_row      <= '0;
    in_cell_col      <= '0;
    in_end_of_string <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_index        <= CFG_SCREEN_ROWS;
    cfg_data         <= '0;
    rst_n            <= 1'b0;
    foreach (screen_image[i]) screen_image[i] = '0;
    model_row      = 0;
    model_col      = 0;
    rows_reg       = ROWS_RST;
    cols_reg       = COLS_RST;
    mismatch_count = 0;
    useful_items   = 0;
    hold_off_req   = 1'b0;
    send_idle_pct  = 18;
    recv_idle_pct  = 60;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_geometry();
    test_tab_and_wrap();
    test_shrink_and_clamp();
    test_clear();
    test_input_backpressure();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
